// ===== src/tqc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tqc_pkg
// Register indexes, register widths and reset values of the triangle
// quality classifier, and the fraction scalings of its compares.
// ----------------------------------------------------------------------------
package tqc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 36;
    localparam int CNT_OUT_W  = 32;

    localparam int AREA_LIM_W = 36;
    localparam int COS_W      = 18;
    localparam int RATIO_W    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_AREA_LIM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_LIM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RAD_LIM  = 3'd4;

    localparam logic [AREA_LIM_W-1:0]   AREA_LIM_RST = 36'd1;
    localparam logic signed [COS_W-1:0] MIN_COS_RST  = 18'sd65526;
    localparam logic signed [COS_W-1:0] MAX_COS_RST  = -18'sd65526;
    localparam logic [RATIO_W-1:0]      EDGE_LIM_RST = 16'd7680;
    localparam logic [RATIO_W-1:0]      RAD_LIM_RST  = 16'd2560;

    // cosine of a zero angle in q1.16
    localparam logic signed [COS_W-1:0] COS_ONE = 18'sd65536;

    // bits of fraction scaling in the cosine and radius compares, the square roots and the edge compare
    localparam int COS_SHIFT = 30;
    localparam int RAD_SHIFT = 25;
    localparam int LEN_FRAC2 = 16;
    localparam int EDGE_FRAC = 8;

endpackage
`default_nettype wire

// ===== src/tqc_tri_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tqc_tri_if
// Input channel: one triangle word of three vertices and a last-face mark.
// ----------------------------------------------------------------------------
interface tqc_tri_if #(parameter int COORD_BITS = 16) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] bz;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;
    logic                         last_face;

    modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, last_face,
                    input ready);
    modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, last_face,
                    output ready);
endinterface
`default_nettype wire

// ===== src/tqc_res_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tqc_res_if
// Result channel: quality flags and running counts of one triangle.
// ----------------------------------------------------------------------------
interface tqc_res_if import tqc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 degenerate;
    logic                 small_area;
    logic                 extreme_angle;
    logic                 high_edge_ratio;
    logic                 high_radius_ratio;
    logic [CNT_OUT_W-1:0] total_count;
    logic [CNT_OUT_W-1:0] degenerate_count;
    logic [CNT_OUT_W-1:0] small_area_count;
    logic [CNT_OUT_W-1:0] extreme_angle_count;
    logic [CNT_OUT_W-1:0] edge_ratio_count;
    logic [CNT_OUT_W-1:0] radius_ratio_count;
    logic                 summary_done;

    modport source (output valid, degenerate, small_area, extreme_angle, high_edge_ratio,
                    high_radius_ratio, total_count, degenerate_count, small_area_count,
                    extreme_angle_count, edge_ratio_count, radius_ratio_count,
                    summary_done, input ready);
    modport sink   (input valid, degenerate, small_area, extreme_angle, high_edge_ratio,
                    high_radius_ratio, total_count, degenerate_count, small_area_count,
                    extreme_angle_count, edge_ratio_count, radius_ratio_count,
                    summary_done, output ready);
endinterface
`default_nettype wire

// ===== src/triangle_quality_classifier_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_quality_classifier_top
// Classifies one triangle per word: degenerate, small area, extreme angle,
// high edge ratio and high radius ratio, with saturating running counts.
// ----------------------------------------------------------------------------
// one triangle runs 41 operations in turn: 38 shift-add multiplies on the one
// shared shift-add multiplier and 3 square roots. input is ready again once
// the result is loaded into the output register. synchronous reset clears the
// counters, the sequencer and the output valid, and loads the register
// defaults.
module triangle_quality_classifier_top import tqc_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int COUNT_BITS = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    tqc_tri_if.sink              i_tri,
    tqc_res_if.source            o_res
);

    localparam int DW  = COORD_BITS + 1;
    localparam int SQW = 2 * DW;
    localparam int CW  = 2 * DW + 1;
    localparam int TW  = 4 * DW;
    localparam int NW  = 2 * DW + 2;
    localparam int NSW = 2 * NW;
    localparam int PQW = 2 * SQW;
    localparam int LW  = DW + 8;
    localparam int SXW = 2 * LW;
    localparam int RW  = LW + 3;
    localparam int T2W = 2 * COS_W;
    localparam int PW  = 4 * DW + 41;
    localparam int AW  = PW + 1;
    localparam int YW  = (NW > T2W) ? NW : T2W;
    localparam int SCW = $clog2(LW + 1);
    localparam int STW = 6;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam logic [STW-1:0] ST_SQ_W0 = 6'd0;
    localparam logic [STW-1:0] ST_SQ_W1 = 6'd1;
    localparam logic [STW-1:0] ST_SQ_W2 = 6'd2;
    localparam logic [STW-1:0] ST_SQ_V0 = 6'd3;
    localparam logic [STW-1:0] ST_SQ_V1 = 6'd4;
    localparam logic [STW-1:0] ST_SQ_V2 = 6'd5;
    localparam logic [STW-1:0] ST_SQ_U0 = 6'd6;
    localparam logic [STW-1:0] ST_SQ_U1 = 6'd7;
    localparam logic [STW-1:0] ST_SQ_U2 = 6'd8;
    localparam logic [STW-1:0] ST_CR0A  = 6'd9;
    localparam logic [STW-1:0] ST_CR0B  = 6'd10;
    localparam logic [STW-1:0] ST_CR1A  = 6'd11;
    localparam logic [STW-1:0] ST_CR1B  = 6'd12;
    localparam logic [STW-1:0] ST_CR2A  = 6'd13;
    localparam logic [STW-1:0] ST_CR2B  = 6'd14;
    localparam logic [STW-1:0] ST_CRS0  = 6'd15;
    localparam logic [STW-1:0] ST_CRS1  = 6'd16;
    localparam logic [STW-1:0] ST_CRS2  = 6'd17;
    localparam logic [STW-1:0] ST_LIM   = 6'd18;
    localparam logic [STW-1:0] ST_NS0   = 6'd19;
    localparam logic [STW-1:0] ST_NS1   = 6'd20;
    localparam logic [STW-1:0] ST_NS2   = 6'd21;
    localparam logic [STW-1:0] ST_PQ0   = 6'd22;
    localparam logic [STW-1:0] ST_PQ1   = 6'd23;
    localparam logic [STW-1:0] ST_PQ2   = 6'd24;
    localparam logic [STW-1:0] ST_T2MIN = 6'd25;
    localparam logic [STW-1:0] ST_T2MAX = 6'd26;
    localparam logic [STW-1:0] ST_CMN0  = 6'd27;
    localparam logic [STW-1:0] ST_CMN1  = 6'd28;
    localparam logic [STW-1:0] ST_CMN2  = 6'd29;
    localparam logic [STW-1:0] ST_CMX0  = 6'd30;
    localparam logic [STW-1:0] ST_CMX1  = 6'd31;
    localparam logic [STW-1:0] ST_CMX2  = 6'd32;
    localparam logic [STW-1:0] ST_SQA   = 6'd33;
    localparam logic [STW-1:0] ST_SQB   = 6'd34;
    localparam logic [STW-1:0] ST_SQC   = 6'd35;
    localparam logic [STW-1:0] ST_NUM0  = 6'd36;
    localparam logic [STW-1:0] ST_NUM1  = 6'd37;
    localparam logic [STW-1:0] ST_NUM2  = 6'd38;
    localparam logic [STW-1:0] ST_DEN   = 6'd39;
    localparam logic [STW-1:0] ST_ER    = 6'd40;

    function automatic logic [DW-1:0] mag_d(input logic [DW-1:0] v);
        logic [DW-1:0] r;
        r = v[DW-1] ? ~v + 1'b1 : v;
        return r;
    endfunction

    function automatic logic [CW-1:0] mag_c(input logic [CW-1:0] v);
        logic [CW-1:0] r;
        r = v[CW-1] ? ~v + 1'b1 : v;
        return r;
    endfunction

    function automatic logic [NW-1:0] mag_n(input logic [NW-1:0] v);
        logic [NW-1:0] r;
        r = v[NW-1] ? ~v + 1'b1 : v;
        return r;
    endfunction

    function automatic logic [COS_W-1:0] mag_t(input logic [COS_W-1:0] v);
        logic [COS_W-1:0] r;
        r = v[COS_W-1] ? ~v + 1'b1 : v;
        return r;
    endfunction

    function automatic logic [DW-1:0] sub_c(input logic [COORD_BITS-1:0] x,
                                            input logic [COORD_BITS-1:0] y);
        logic [DW-1:0] r;
        r = {x[COORD_BITS-1], x} - {y[COORD_BITS-1], y};
        return r;
    endfunction

    // {gt, lt} of n / (2 sqrt(pq)) against t / 65536, given the squared compare
    function automatic logic [1:0] cos_cmp(input logic n_neg, input logic n_zero,
                                           input logic t_neg, input logic t_zero,
                                           input logic m_gt, input logic m_lt);
        int sx;
        int sy;
        logic [1:0] r;
        sx = n_zero ? 0 : (n_neg ? -1 : 1);
        sy = t_zero ? 0 : (t_neg ? -1 : 1);
        if (sx != sy) begin
            r = {sx > sy, sx < sy};
        end else if (sx == 0) begin
            r = 2'b00;
        end else if (sx > 0) begin
            r = {m_gt, m_lt};
        end else begin
            r = {m_lt, m_gt};
        end
        return r;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c,
                                                      input logic f);
        logic [COUNT_BITS-1:0] r;
        r = (f && (c != '1)) ? c + 1'b1 : c;
        return r;
    endfunction

    // control
    logic [2:0]     r_state;
    logic [STW-1:0] r_step;
    logic           r_ovalid;

    // configuration
    logic [AREA_LIM_W-1:0]   r_alim;
    logic signed [COS_W-1:0] r_tmin;
    logic signed [COS_W-1:0] r_tmax;
    logic [RATIO_W-1:0]      r_elim;
    logic [RATIO_W-1:0]      r_rlim;

    logic [COUNT_BITS-1:0] r_cnt [6];

    // datapath
    logic [DW-1:0]  r_d [9];
    logic           r_last;
    logic [SQW-1:0] r_asq;
    logic [SQW-1:0] r_bsq;
    logic [SQW-1:0] r_csq;
    logic [CW-1:0]  r_cr [3];
    logic [TW-1:0]  r_tsq;
    logic [NSW-1:0] r_nsq [3];
    logic [PQW-1:0] r_pq [3];
    logic [T2W-1:0] r_t2min;
    logic [T2W-1:0] r_t2max;
    logic [LW-1:0]  r_l8 [3];
    logic [PW-1:0]  r_num;
    logic           r_small;
    logic           r_ext;
    logic           r_er;
    logic           r_rr;

    logic [PW-1:0]        r_x;
    logic [YW-1:0]        r_y;
    logic                 r_neg;
    logic signed [AW-1:0] r_acc;
    logic [SXW-1:0]       r_sx;
    logic [RW-1:0]        r_rem;
    logic [LW-1:0]        r_root;
    logic [SCW-1:0]       r_scnt;

    logic                 r_o_deg;
    logic                 r_o_small;
    logic                 r_o_ext;
    logic                 r_o_er;
    logic                 r_o_rr;
    logic [CNT_OUT_W-1:0] r_o_cnt [6];
    logic                 r_o_done;

    // operation table
    logic [PW-1:0]  op_x;
    logic [YW-1:0]  op_y;
    logic           op_neg;
    logic           op_chain;
    logic           op_sqrt;
    logic [SQW-1:0] op_sq;

    logic signed [NW-1:0] n_n [3];
    logic [PW-1:0]        acc_u;
    logic signed [AW-1:0] acc_add;
    logic                 mul_end;
    logic [1:0]           cmp_k;
    logic signed [COS_W-1:0] cmp_t;
    logic [PW-1:0]        cmp_lhs;
    logic [1:0]           cmp_res;
    logic [LW-1:0]        l8_hi;
    logic [LW-1:0]        l8_lo;
    logic [LW+1:0]        l8_sum;
    logic [RW-1:0]        sq_rem_t;
    logic [RW-1:0]        sq_trial;

    logic                  f_deg;
    logic                  f_ext;
    logic                  f_er;
    logic                  f_rr;
    logic [COUNT_BITS-1:0] cnt_nx [6];
    logic                  out_load;
    logic                  in_acc;

    assign in_acc   = i_tri.valid && i_tri.ready;
    assign out_load = (r_state == S_FIN) && (!r_ovalid || o_res.ready);
    assign i_tri.ready = (r_state == S_IDLE);

    assign n_n[0] = $signed({2'b00, r_bsq}) + $signed({2'b00, r_csq}) - $signed({2'b00, r_asq});
    assign n_n[1] = $signed({2'b00, r_asq}) + $signed({2'b00, r_csq}) - $signed({2'b00, r_bsq});
    assign n_n[2] = $signed({2'b00, r_asq}) + $signed({2'b00, r_bsq}) - $signed({2'b00, r_csq});

    assign acc_u   = r_acc[PW-1:0];
    assign acc_add = r_neg ? -$signed({1'b0, r_x}) : $signed({1'b0, r_x});
    assign mul_end = (r_y == '0);

    assign l8_hi  = (r_l8[0] > r_l8[1]) ? ((r_l8[0] > r_l8[2]) ? r_l8[0] : r_l8[2])
                                        : ((r_l8[1] > r_l8[2]) ? r_l8[1] : r_l8[2]);
    assign l8_lo  = (r_l8[0] < r_l8[1]) ? ((r_l8[0] < r_l8[2]) ? r_l8[0] : r_l8[2])
                                        : ((r_l8[1] < r_l8[2]) ? r_l8[1] : r_l8[2]);
    assign l8_sum = {2'b00, r_l8[0]} + {2'b00, r_l8[1]} + {2'b00, r_l8[2]};

    assign sq_rem_t = {r_rem[RW-3:0], r_sx[SXW-1 -: 2]};
    assign sq_trial = RW'({r_root, 2'b01});

    always_comb begin
        unique case (r_step)
            ST_CMN1, ST_CMX1: cmp_k = 2'd1;
            ST_CMN2, ST_CMX2: cmp_k = 2'd2;
            default:          cmp_k = 2'd0;
        endcase
        cmp_t   = (r_step >= ST_CMX0) ? r_tmax : r_tmin;
        cmp_lhs = PW'({r_nsq[cmp_k], {COS_SHIFT{1'b0}}});
        cmp_res = cos_cmp(n_n[cmp_k][NW-1], n_n[cmp_k] == '0, cmp_t[COS_W-1],
                          cmp_t == '0, cmp_lhs > acc_u, cmp_lhs < acc_u);
    end

    always_comb begin
        op_x     = '0;
        op_y     = '0;
        op_neg   = 1'b0;
        op_chain = 1'b0;
        op_sqrt  = 1'b0;
        op_sq    = '0;
        unique case (r_step)
            ST_SQ_W0: begin
                op_x = PW'(mag_d(r_d[6]));
                op_y = YW'(mag_d(r_d[6]));
            end
            ST_SQ_W1: begin
                op_x = PW'(mag_d(r_d[7]));
                op_y = YW'(mag_d(r_d[7]));
                op_chain = 1'b1;
            end
            ST_SQ_W2: begin
                op_x = PW'(mag_d(r_d[8]));
                op_y = YW'(mag_d(r_d[8]));
                op_chain = 1'b1;
            end
            ST_SQ_V0: begin
                op_x = PW'(mag_d(r_d[3]));
                op_y = YW'(mag_d(r_d[3]));
            end
            ST_SQ_V1: begin
                op_x = PW'(mag_d(r_d[4]));
                op_y = YW'(mag_d(r_d[4]));
                op_chain = 1'b1;
            end
            ST_SQ_V2: begin
                op_x = PW'(mag_d(r_d[5]));
                op_y = YW'(mag_d(r_d[5]));
                op_chain = 1'b1;
            end
            ST_SQ_U0: begin
                op_x = PW'(mag_d(r_d[0]));
                op_y = YW'(mag_d(r_d[0]));
            end
            ST_SQ_U1: begin
                op_x = PW'(mag_d(r_d[1]));
                op_y = YW'(mag_d(r_d[1]));
                op_chain = 1'b1;
            end
            ST_SQ_U2: begin
                op_x = PW'(mag_d(r_d[2]));
                op_y = YW'(mag_d(r_d[2]));
                op_chain = 1'b1;
            end
            ST_CR0A: begin
                op_x   = PW'(mag_d(r_d[1]));
                op_y   = YW'(mag_d(r_d[5]));
                op_neg = r_d[1][DW-1] ^ r_d[5][DW-1];
            end
            ST_CR0B: begin
                op_x     = PW'(mag_d(r_d[2]));
                op_y     = YW'(mag_d(r_d[4]));
                op_neg   = ~(r_d[2][DW-1] ^ r_d[4][DW-1]);
                op_chain = 1'b1;
            end
            ST_CR1A: begin
                op_x   = PW'(mag_d(r_d[2]));
                op_y   = YW'(mag_d(r_d[3]));
                op_neg = r_d[2][DW-1] ^ r_d[3][DW-1];
            end
            ST_CR1B: begin
                op_x     = PW'(mag_d(r_d[0]));
                op_y     = YW'(mag_d(r_d[5]));
                op_neg   = ~(r_d[0][DW-1] ^ r_d[5][DW-1]);
                op_chain = 1'b1;
            end
            ST_CR2A: begin
                op_x   = PW'(mag_d(r_d[0]));
                op_y   = YW'(mag_d(r_d[4]));
                op_neg = r_d[0][DW-1] ^ r_d[4][DW-1];
            end
            ST_CR2B: begin
                op_x     = PW'(mag_d(r_d[1]));
                op_y     = YW'(mag_d(r_d[3]));
                op_neg   = ~(r_d[1][DW-1] ^ r_d[3][DW-1]);
                op_chain = 1'b1;
            end
            ST_CRS0: begin
                op_x = PW'(mag_c(r_cr[0]));
                op_y = YW'(mag_c(r_cr[0]));
            end
            ST_CRS1: begin
                op_x = PW'(mag_c(r_cr[1]));
                op_y = YW'(mag_c(r_cr[1]));
                op_chain = 1'b1;
            end
            ST_CRS2: begin
                op_x = PW'(mag_c(r_cr[2]));
                op_y = YW'(mag_c(r_cr[2]));
                op_chain = 1'b1;
            end
            ST_LIM: begin
                op_x = PW'(r_alim);
                op_y = YW'(r_alim);
            end
            ST_NS0: begin
                op_x = PW'(mag_n(n_n[0]));
                op_y = YW'(mag_n(n_n[0]));
            end
            ST_NS1: begin
                op_x = PW'(mag_n(n_n[1]));
                op_y = YW'(mag_n(n_n[1]));
            end
            ST_NS2: begin
                op_x = PW'(mag_n(n_n[2]));
                op_y = YW'(mag_n(n_n[2]));
            end
            ST_PQ0: begin
                op_x = PW'(r_bsq);
                op_y = YW'(r_csq);
            end
            ST_PQ1: begin
                op_x = PW'(r_asq);
                op_y = YW'(r_csq);
            end
            ST_PQ2: begin
                op_x = PW'(r_asq);
                op_y = YW'(r_bsq);
            end
            ST_T2MIN: begin
                op_x = PW'(mag_t(r_tmin));
                op_y = YW'(mag_t(r_tmin));
            end
            ST_T2MAX: begin
                op_x = PW'(mag_t(r_tmax));
                op_y = YW'(mag_t(r_tmax));
            end
            ST_CMN0: begin
                op_x = PW'(r_pq[0]);
                op_y = YW'(r_t2min);
            end
            ST_CMN1: begin
                op_x = PW'(r_pq[1]);
                op_y = YW'(r_t2min);
            end
            ST_CMN2: begin
                op_x = PW'(r_pq[2]);
                op_y = YW'(r_t2min);
            end
            ST_CMX0: begin
                op_x = PW'(r_pq[0]);
                op_y = YW'(r_t2max);
            end
            ST_CMX1: begin
                op_x = PW'(r_pq[1]);
                op_y = YW'(r_t2max);
            end
            ST_CMX2: begin
                op_x = PW'(r_pq[2]);
                op_y = YW'(r_t2max);
            end
            ST_SQA: begin
                op_sqrt = 1'b1;
                op_sq   = r_asq;
            end
            ST_SQB: begin
                op_sqrt = 1'b1;
                op_sq   = r_bsq;
            end
            ST_SQC: begin
                op_sqrt = 1'b1;
                op_sq   = r_csq;
            end
            ST_NUM0: begin
                op_x = PW'(r_l8[0]);
                op_y = YW'(r_l8[1]);
            end
            ST_NUM1: begin
                op_x = r_num;
                op_y = YW'(r_l8[2]);
            end
            ST_NUM2: begin
                op_x = r_num;
                op_y = YW'(l8_sum);
            end
            ST_DEN: begin
                op_x = PW'(r_tsq);
                op_y = YW'(r_rlim);
            end
            ST_ER: begin
                op_x = PW'(l8_lo);
                op_y = YW'(r_elim);
            end
            default: begin
                op_x = '0;
            end
        endcase
    end

    // final flags and counts
    always_comb begin
        f_deg = (r_asq == '0) || (r_bsq == '0) || (r_csq == '0);
        f_ext = f_deg ? ((COS_ONE > r_tmin) || (COS_ONE < r_tmax)) : r_ext;
        f_er  = f_deg ? 1'b0 : r_er;
        f_rr  = f_deg ? 1'b0 : ((r_tsq == '0) ? 1'b1 : r_rr);
        cnt_nx[0] = sat_inc(r_cnt[0], 1'b1);
        cnt_nx[1] = sat_inc(r_cnt[1], f_deg);
        cnt_nx[2] = sat_inc(r_cnt[2], r_small);
        cnt_nx[3] = sat_inc(r_cnt[3], f_ext);
        cnt_nx[4] = sat_inc(r_cnt[4], f_er);
        cnt_nx[5] = sat_inc(r_cnt[5], f_rr);
    end

    // sequencer, configuration and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= ST_SQ_W0;
            r_ovalid <= 1'b0;
            r_alim   <= AREA_LIM_RST;
            r_tmin   <= MIN_COS_RST;
            r_tmax   <= MAX_COS_RST;
            r_elim   <= EDGE_LIM_RST;
            r_rlim   <= RAD_LIM_RST;
            for (int i = 0; i < 6; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_AREA_LIM: r_alim <= i_cfg_data[AREA_LIM_W-1:0];
                    REG_MIN_COS:  r_tmin <= i_cfg_data[COS_W-1:0];
                    REG_MAX_COS:  r_tmax <= i_cfg_data[COS_W-1:0];
                    REG_EDGE_LIM: r_elim <= i_cfg_data[RATIO_W-1:0];
                    REG_RAD_LIM:  r_rlim <= i_cfg_data[RATIO_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_res.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_step  <= ST_SQ_W0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= op_sqrt ? S_SQRT : S_MUL;
                end
                S_MUL: begin
                    if (mul_end) begin
                        if (r_step == ST_ER) begin
                            r_state <= S_FIN;
                        end else begin
                            r_step  <= r_step + 1'b1;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_SQRT: begin
                    if (r_scnt == '0) begin
                        r_step  <= r_step + 1'b1;
                        r_state <= S_LOAD;
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_state  <= S_IDLE;
                        for (int i = 0; i < 6; i++) begin
                            r_cnt[i] <= r_last ? '0 : cnt_nx[i];
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_d[0] <= sub_c(i_tri.bx, i_tri.ax);
            r_d[1] <= sub_c(i_tri.by, i_tri.ay);
            r_d[2] <= sub_c(i_tri.bz, i_tri.az);
            r_d[3] <= sub_c(i_tri.cx, i_tri.ax);
            r_d[4] <= sub_c(i_tri.cy, i_tri.ay);
            r_d[5] <= sub_c(i_tri.cz, i_tri.az);
            r_d[6] <= sub_c(i_tri.cx, i_tri.bx);
            r_d[7] <= sub_c(i_tri.cy, i_tri.by);
            r_d[8] <= sub_c(i_tri.cz, i_tri.bz);
            r_last <= i_tri.last_face;
            r_ext  <= 1'b0;
        end

        if (r_state == S_LOAD) begin
            r_x   <= op_x;
            r_y   <= op_y;
            r_neg <= op_neg;
            if (!op_chain) begin
                r_acc <= '0;
            end
            r_sx   <= {op_sq, {LEN_FRAC2{1'b0}}};
            r_rem  <= '0;
            r_root <= '0;
            r_scnt <= SCW'(LW);
        end

        if (r_state == S_MUL) begin
            if (mul_end) begin
                unique case (r_step)
                    ST_SQ_W2: r_asq <= acc_u[SQW-1:0];
                    ST_SQ_V2: r_bsq <= acc_u[SQW-1:0];
                    ST_SQ_U2: r_csq <= acc_u[SQW-1:0];
                    ST_CR0B:  r_cr[0] <= acc_u[CW-1:0];
                    ST_CR1B:  r_cr[1] <= acc_u[CW-1:0];
                    ST_CR2B:  r_cr[2] <= acc_u[CW-1:0];
                    ST_CRS2:  r_tsq <= acc_u[TW-1:0];
                    ST_LIM:   r_small <= PW'(r_tsq) < acc_u;
                    ST_NS0:   r_nsq[0] <= acc_u[NSW-1:0];
                    ST_NS1:   r_nsq[1] <= acc_u[NSW-1:0];
                    ST_NS2:   r_nsq[2] <= acc_u[NSW-1:0];
                    ST_PQ0:   r_pq[0] <= acc_u[PQW-1:0];
                    ST_PQ1:   r_pq[1] <= acc_u[PQW-1:0];
                    ST_PQ2:   r_pq[2] <= acc_u[PQW-1:0];
                    ST_T2MIN: r_t2min <= acc_u[T2W-1:0];
                    ST_T2MAX: r_t2max <= acc_u[T2W-1:0];
                    ST_CMN0, ST_CMN1, ST_CMN2: r_ext <= r_ext | cmp_res[1];
                    ST_CMX0, ST_CMX1, ST_CMX2: r_ext <= r_ext | cmp_res[0];
                    ST_NUM0, ST_NUM1, ST_NUM2: r_num <= acc_u;
                    ST_DEN:   r_rr <= r_num > {acc_u[PW-RAD_SHIFT-1:0], {RAD_SHIFT{1'b0}}};
                    ST_ER:    r_er <= PW'({l8_hi, {EDGE_FRAC{1'b0}}}) > acc_u;
                    default: begin
                    end
                endcase
            end else begin
                if (r_y[0]) begin
                    r_acc <= r_acc + acc_add;
                end
                r_x <= {r_x[PW-2:0], 1'b0};
                r_y <= {1'b0, r_y[YW-1:1]};
            end
        end

        if (r_state == S_SQRT) begin
            if (r_scnt == '0) begin
                unique case (r_step)
                    ST_SQA:  r_l8[0] <= r_root;
                    ST_SQB:  r_l8[1] <= r_root;
                    ST_SQC:  r_l8[2] <= r_root;
                    default: begin
                    end
                endcase
            end else begin
                r_sx   <= {r_sx[SXW-3:0], 2'b00};
                r_scnt <= r_scnt - 1'b1;
                if (sq_rem_t >= sq_trial) begin
                    r_rem  <= sq_rem_t - sq_trial;
                    r_root <= {r_root[LW-2:0], 1'b1};
                end else begin
                    r_rem  <= sq_rem_t;
                    r_root <= {r_root[LW-2:0], 1'b0};
                end
            end
        end

        if (out_load) begin
            r_o_deg   <= f_deg;
            r_o_small <= r_small;
            r_o_ext   <= f_ext;
            r_o_er    <= f_er;
            r_o_rr    <= f_rr;
            r_o_done  <= r_last;
            for (int i = 0; i < 6; i++) begin
                r_o_cnt[i] <= CNT_OUT_W'(cnt_nx[i]);
            end
        end
    end

    assign o_res.valid               = r_ovalid;
    assign o_res.degenerate          = r_o_deg;
    assign o_res.small_area          = r_o_small;
    assign o_res.extreme_angle       = r_o_ext;
    assign o_res.high_edge_ratio     = r_o_er;
    assign o_res.high_radius_ratio   = r_o_rr;
    assign o_res.total_count         = r_o_cnt[0];
    assign o_res.degenerate_count    = r_o_cnt[1];
    assign o_res.small_area_count    = r_o_cnt[2];
    assign o_res.extreme_angle_count = r_o_cnt[3];
    assign o_res.edge_ratio_count    = r_o_cnt[4];
    assign o_res.radius_ratio_count  = r_o_cnt[5];
    assign o_res.summary_done        = r_o_done;

endmodule
`default_nettype wire

// ===== tb/sv/triangle_quality_classifier_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_quality_classifier_top_tb
// Drives triangles through the classifier under random bursts, gaps and
// output stalls. Each accepted triangle is classified by an exact wide-integer
// predictor, and each result word is checked field by field. The run passes
// through default, extreme and random threshold settings.
// ----------------------------------------------------------------------------
module triangle_quality_classifier_top_tb;
    import tqc_pkg::*;

    typedef struct {
        logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
        logic               last_face;
    } tri_word_t;

    typedef struct {
        logic        degenerate, small_area, extreme_angle, high_edge_ratio;
        logic        high_radius_ratio, summary_done;
        logic [31:0] total_count, degenerate_count, small_area_count;
        logic [31:0] extreme_angle_count, edge_ratio_count, radius_ratio_count;
    } quality_t;

    localparam longint unsigned CNT_TOP = 64'hFFFF_FFFF;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tqc_tri_if #(.COORD_BITS(16)) tri_ch ();
    tqc_res_if                    res_ch ();

    triangle_quality_classifier_top #(.COORD_BITS(16), .COUNT_BITS(32)) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_tri     (tri_ch.sink),
        .o_res     (res_ch.source)
    );

    // threshold copies
    longint unsigned area_lim;
    int              min_cos, max_cos;
    longint unsigned edge_lim, rad_lim;

    // running counts
    longint unsigned n_total, n_deg, n_small, n_ext, n_edge, n_rad;

    tri_word_t tri_q[$];
    quality_t  quality_q[$];
    int        errors, words_in, words_out, faces_last;
    bit        tri_taken, hold_req;
    int        gap_left, burst_left, hold_left, rx_cycle;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint unsigned sqrt_q8(longint unsigned sq);
        logic [255:0] x, c2;
        longint unsigned r, c;
        x = 256'(sq) << 16;
        r = 0;
        for (int b = 40; b >= 0; b--) begin
            c  = r | (64'd1 << b);
            c2 = 256'(c) * 256'(c);
            if (c2 <= x) r = c;
        end
        return r;
    endfunction

    // sign of n / (2 sqrt(p q)) - t / 65536
    function automatic int cos_order(longint n, longint unsigned p, longint unsigned q, int t);
        int sn, st;
        longint unsigned nm, tm;
        logic [255:0] lhs, rhs;
        sn = (n > 0) - (n < 0);
        st = (t > 0) - (t < 0);
        if (sn != st) return sn > st ? 1 : -1;
        if (sn == 0) return 0;
        nm  = n < 0 ? -n : n;
        tm  = t < 0 ? -t : t;
        lhs = (256'(nm) * 256'(nm)) << COS_SHIFT;
        rhs = 256'(tm) * 256'(tm) * 256'(p) * 256'(q);
        if (lhs == rhs) return 0;
        return ((lhs > rhs) ? 1 : -1) * sn;
    endfunction

    function automatic longint unsigned cnt_step(longint unsigned c, bit f);
        if (!f) return c;
        return c >= CNT_TOP ? CNT_TOP : c + 1;
    endfunction

    function automatic quality_t classify(tri_word_t w);
        quality_t        r;
        longint          u[3], v[3], d[3], cr[3], na, nb, nc;
        longint unsigned asq, bsq, csq, a8, b8, c8, hi, lo;
        logic [255:0]    tsq, num, den;
        bit              deg, low_area, ext, er, rr;
        u[0] = longint'(w.bx) - w.ax; u[1] = longint'(w.by) - w.ay;
        u[2] = longint'(w.bz) - w.az;
        v[0] = longint'(w.cx) - w.ax; v[1] = longint'(w.cy) - w.ay;
        v[2] = longint'(w.cz) - w.az;
        d[0] = longint'(w.cx) - w.bx; d[1] = longint'(w.cy) - w.by;
        d[2] = longint'(w.cz) - w.bz;
        asq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        bsq = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        csq = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
        cr[0] = u[1] * v[2] - u[2] * v[1];
        cr[1] = u[2] * v[0] - u[0] * v[2];
        cr[2] = u[0] * v[1] - u[1] * v[0];
        tsq = '0;
        for (int i = 0; i < 3; i++)
            tsq += 256'(cr[i] < 0 ? -cr[i] : cr[i]) * 256'(cr[i] < 0 ? -cr[i] : cr[i]);
        deg      = (asq == 0) || (bsq == 0) || (csq == 0);
        low_area = tsq < 256'(area_lim) * 256'(area_lim);
        er = 0;
        rr = 0;
        if (deg) begin
            ext = (65536 > min_cos) || (65536 < max_cos);
        end else begin
            na  = longint'(bsq + csq) - longint'(asq);
            nb  = longint'(asq + csq) - longint'(bsq);
            nc  = longint'(asq + bsq) - longint'(csq);
            ext = cos_order(na, bsq, csq, min_cos) > 0 || cos_order(nb, asq, csq, min_cos) > 0
               || cos_order(nc, asq, bsq, min_cos) > 0 || cos_order(na, bsq, csq, max_cos) < 0
               || cos_order(nb, asq, csq, max_cos) < 0 || cos_order(nc, asq, bsq, max_cos) < 0;
            a8 = sqrt_q8(asq);
            b8 = sqrt_q8(bsq);
            c8 = sqrt_q8(csq);
            hi = a8 > b8 ? a8 : b8;
            hi = hi > c8 ? hi : c8;
            lo = a8 < b8 ? a8 : b8;
            lo = lo < c8 ? lo : c8;
            er = hi * 256 > edge_lim * lo;
            if (tsq == 0) begin
                rr = 1;
            end else begin
                num = 256'(a8) * 256'(b8) * 256'(c8) * 256'(a8 + b8 + c8);
                den = (tsq * 256'(rad_lim)) << RAD_SHIFT;
                rr  = num > den;
            end
        end
        n_total = cnt_step(n_total, 1);
        n_deg   = cnt_step(n_deg, deg);
        n_small = cnt_step(n_small, low_area);
        n_ext   = cnt_step(n_ext, ext);
        n_edge  = cnt_step(n_edge, er);
        n_rad   = cnt_step(n_rad, rr);
        r.degenerate          = deg;
        r.small_area          = low_area;
        r.extreme_angle       = ext;
        r.high_edge_ratio     = er;
        r.high_radius_ratio   = rr;
        r.summary_done        = w.last_face;
        r.total_count         = n_total[31:0];
        r.degenerate_count    = n_deg[31:0];
        r.small_area_count    = n_small[31:0];
        r.extreme_angle_count = n_ext[31:0];
        r.edge_ratio_count    = n_edge[31:0];
        r.radius_ratio_count  = n_rad[31:0];
        if (w.last_face) begin
            n_total = 0; n_deg = 0; n_small = 0; n_ext = 0; n_edge = 0; n_rad = 0;
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // input acceptance and result checking
    always @(posedge i_clk) begin
        quality_t  q;
        tri_word_t w;
        if (i_rst_n && tri_ch.valid && tri_ch.ready) begin
            w = '{tri_ch.ax, tri_ch.ay, tri_ch.az, tri_ch.bx, tri_ch.by, tri_ch.bz,
                  tri_ch.cx, tri_ch.cy, tri_ch.cz, tri_ch.last_face};
            quality_q.push_back(classify(w));
            tri_taken = 1;
            words_in++;
            if (w.last_face) faces_last++;
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            words_out++;
            if (quality_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result word", $time);
            end else begin
                q = quality_q.pop_front();
                check_field("degenerate", q.degenerate, res_ch.degenerate);
                check_field("small_area", q.small_area, res_ch.small_area);
                check_field("extreme_angle", q.extreme_angle, res_ch.extreme_angle);
                check_field("high_edge_ratio", q.high_edge_ratio, res_ch.high_edge_ratio);
                check_field("high_radius_ratio", q.high_radius_ratio, res_ch.high_radius_ratio);
                check_field("total_count", q.total_count, res_ch.total_count);
                check_field("degenerate_count", q.degenerate_count, res_ch.degenerate_count);
                check_field("small_area_count", q.small_area_count, res_ch.small_area_count);
                check_field("extreme_angle_count", q.extreme_angle_count,
                            res_ch.extreme_angle_count);
                check_field("edge_ratio_count", q.edge_ratio_count, res_ch.edge_ratio_count);
                check_field("radius_ratio_count", q.radius_ratio_count,
                            res_ch.radius_ratio_count);
                check_field("summary_done", q.summary_done, res_ch.summary_done);
            end
        end
    end

    // sender: bursts with random gaps
    always @(negedge i_clk) begin
        tri_word_t w;
        if (!i_rst_n) begin
            tri_ch.valid <= 1'b0;
        end else if (!(tri_ch.valid && !tri_taken)) begin
            tri_taken = 0;
            if (gap_left > 0 || tri_q.size() == 0) begin
                tri_ch.valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                w = tri_q.pop_front();
                tri_ch.ax <= w.ax; tri_ch.ay <= w.ay; tri_ch.az <= w.az;
                tri_ch.bx <= w.bx; tri_ch.by <= w.by; tri_ch.bz <= w.bz;
                tri_ch.cx <= w.cx; tri_ch.cy <= w.cy; tri_ch.cz <= w.cz;
                tri_ch.last_face <= w.last_face;
                tri_ch.valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    case ($urandom_range(0, 7))
                        0, 1, 2: gap_left = 0;
                        3:       gap_left = $urandom_range(200, 1500);
                        default: gap_left = $urandom_range(1, 40);
                    endcase
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // receiver: alternating stall pattern plus one long hold-off
    always @(negedge i_clk) begin
        rx_cycle++;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 0;
            hold_left = 5000;
            res_ch.ready <= 1'b0;
        end else if (rx_cycle % 6000 < 3000) begin
            res_ch.ready <= 1'b1;
        end else begin
            res_ch.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_AREA_LIM: area_lim = data;
            REG_MIN_COS:  min_cos  = int'($signed(data[COS_W-1:0]));
            REG_MAX_COS:  max_cos  = int'($signed(data[COS_W-1:0]));
            REG_EDGE_LIM: edge_lim = data[RATIO_W-1:0];
            REG_RAD_LIM:  rad_lim  = data[RATIO_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_limits(longint unsigned a, int mn, int mx, int e, int r);
        write_reg(REG_AREA_LIM, CFG_DATA_W'(a));
        write_reg(REG_MIN_COS, 36'(mn));
        write_reg(REG_MAX_COS, 36'(mx));
        write_reg(REG_EDGE_LIM, 36'(e));
        write_reg(REG_RAD_LIM, 36'(r));
    endtask

    task automatic drain();
        while (tri_q.size() != 0 || quality_q.size() != 0 || tri_ch.valid) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic tri_word_t make_tri(int c[9], bit last);
        tri_word_t w;
        w = '{16'(c[0]), 16'(c[1]), 16'(c[2]), 16'(c[3]), 16'(c[4]), 16'(c[5]),
              16'(c[6]), 16'(c[7]), 16'(c[8]), last};
        return w;
    endfunction

    function automatic tri_word_t rand_tri();
        int c[9], k, base, span;
        span = $urandom_range(0, 3) == 0 ? 2000 : 40;
        for (int i = 0; i < 9; i++) c[i] = $signed(16'($urandom()));
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4, 5, 6: begin
                for (int i = 0; i < 3; i++) begin
                    base = $urandom_range(0, 60000) - 30000;
                    c[i]     = base + $urandom_range(0, 2 * span) - span;
                    c[i + 3] = base + $urandom_range(0, 2 * span) - span;
                    c[i + 6] = base + $urandom_range(0, 2 * span) - span;
                end
            end
            7, 8: begin
                // one vertex repeated
                k = $urandom_range(0, 2);
                for (int i = 0; i < 3; i++) c[3 * ((k + 1) % 3) + i] = c[3 * k + i];
            end
            default: begin
                // collinear points
                for (int i = 0; i < 3; i++) begin
                    base = $urandom_range(0, 20000) - 10000;
                    k    = $urandom_range(0, 200) - 100;
                    c[i]     = base;
                    c[i + 3] = base + k;
                    c[i + 6] = base + 2 * k;
                end
            end
        endcase
        return make_tri(c, $urandom_range(0, 24) == 0);
    endfunction

    task automatic run_random(int count);
        repeat (count) tri_q.push_back(rand_tri());
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        tri_ch.valid = 1'b0; tri_ch.last_face = 1'b0;
        tri_ch.ax = '0; tri_ch.ay = '0; tri_ch.az = '0; tri_ch.bx = '0; tri_ch.by = '0;
        tri_ch.bz = '0; tri_ch.cx = '0; tri_ch.cy = '0; tri_ch.cz = '0;
        res_ch.ready = 1'b0;
        area_lim = AREA_LIM_RST; min_cos = MIN_COS_RST; max_cos = MAX_COS_RST;
        edge_lim = EDGE_LIM_RST; rad_lim = RAD_LIM_RST;
        n_total = 0; n_deg = 0; n_small = 0; n_ext = 0; n_edge = 0; n_rad = 0;
        errors = 0; words_in = 0; words_out = 0; faces_last = 0;
        tri_taken = 0; hold_req = 0; gap_left = 0; burst_left = 0;
        hold_left = 0; rx_cycle = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, degenerate, collinear, common shapes
        tri_q.push_back(make_tri('{32767, 32767, 32767, -32768, -32768, -32768,
                                   32767, -32768, 32767}, 0));
        tri_q.push_back(make_tri('{-32768, 32767, -32768, 32767, -32768, 32767,
                                   -32768, -32768, 32767}, 0));
        tri_q.push_back(make_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 0));
        tri_q.push_back(make_tri('{5, 5, 5, 5, 5, 5, 9, 1, 2}, 0));
        tri_q.push_back(make_tri('{1, 2, 3, 7, 7, 7, 1, 2, 3}, 0));
        tri_q.push_back(make_tri('{0, 0, 0, 3, 0, 0, 3, 4, 0}, 0));
        tri_q.push_back(make_tri('{0, 0, 0, 1, 2, 3, 2, 4, 6}, 0));
        tri_q.push_back(make_tri('{0, 0, 0, 1, 0, 0, 32767, 1, 0}, 0));
        tri_q.push_back(make_tri('{0, 0, 0, 100, 0, 0, 50, 87, 0}, 0));
        tri_q.push_back(make_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0}, 0));
        tri_q.push_back(make_tri('{-32768, 0, 0, 32767, 0, 0, 0, 1, 0}, 0));
        tri_q.push_back(make_tri('{-32768, -32768, -32768, 32767, 32767, 32767,
                                   -32768, -32768, -32768}, 0));
        tri_q.push_back(make_tri('{10, 20, 30, 11, 20, 30, 10, 21, 30}, 1));
        tri_q.push_back(make_tri('{0, 0, 0, 2, 0, 0, 1, 1, 1}, 1));
        drain();
        run_random(200);

        // area and angle flags cannot trip; ratio limits at their maximum
        set_limits(0, 65536, -65536, 65535, 65535);
        run_random(200);

        // every limit at its tripping end; degenerate triangles still clear both ratio flags
        set_limits(64'd34359738368, -65536, 65536, 0, 0);
        hold_req = 1;
        run_random(200);

        set_limits($urandom_range(1, 5000), 56756, -65527, 2560, 512);
        run_random(250);

        for (int k = 0; k < 2; k++) begin
            set_limits({$urandom_range(0, 7), $urandom()}, $urandom_range(0, 131072) - 65536,
                       $signed(18'($urandom())), $urandom_range(0, 65535),
                       $urandom_range(0, 65535));
            run_random(125);
        end

        set_limits(AREA_LIM_RST, MIN_COS_RST, MAX_COS_RST, EDGE_LIM_RST, RAD_LIM_RST);
        run_random(250);

        repeat (50) @(posedge i_clk);
        $display("covered %0d triangles in, %0d results out, %0d mesh ends", words_in,
                 words_out, faces_last);
        $display("threshold sets: reset, all-off, all-on, tight, two random, reset again");
        if (errors == 0 && quality_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #400_000_000;
        $display("timeout");
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tqc_pkg.sv
src/tqc_tri_if.sv
src/tqc_res_if.sv
src/triangle_quality_classifier_top.sv
tb/sv/triangle_quality_classifier_top_tb.sv
